@@ sv/blake2b_pkg.sv @@
// Shared types, constants and message schedule for the BLAKE2b compression block.
package blake2b_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_CHAIN = 2'd0,
    ACT_LOAD_MSG   = 2'd1,
    ACT_COMPRESS   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  index;
    logic [63:0] word;
    logic [63:0] counter_low;
    logic [63:0] counter_high;
    logic        final_block;
    logic        last_node;
  } blk_req_t;

  typedef struct packed {
    logic [63:0] hash_word;
    logic [2:0]  word_index;
    logic        last;
  } blk_res_t;

  // One column of the work vector as seen by the mixing unit.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } g_quad_t;

  localparam int unsigned Rounds   = 12;
  localparam int unsigned MsgDepth = 16;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  // Message schedule per round; nibble i of a row is the message index of slot i.
  localparam logic [63:0] SIGMA_ROWS [Rounds] = '{
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE,
    64'h491763EADF250C8B, 64'h8F04A562EBCD1397,
    64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD,
    64'h5A417D2C803B9EF6, 64'h0DC3E9BF5167482A,
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE
  };

endpackage

@@ sv/blake2b_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module blake2b_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/blake2b_g_unit.sv @@
// Shared mixing unit: one quarter of a G function per cycle, one adder and one rotator.
module blake2b_g_unit (
  input  logic [1:0]          phase,
  input  blake2b_pkg::g_quad_t quad_in,
  input  logic [63:0]         msg_word,
  output blake2b_pkg::g_quad_t quad_out
);
  import blake2b_pkg::*;

  logic [63:0] op_x;
  logic [63:0] op_y;
  logic [63:0] op_m;
  logic [63:0] sum;
  logic [63:0] mixed;
  logic [63:0] rotated;

  // Even phases update a then d with a message word, odd phases update c then b.
  assign op_x  = phase[0] ? quad_in.c : quad_in.a;
  assign op_y  = phase[0] ? quad_in.d : quad_in.b;
  assign op_m  = phase[0] ? 64'd0 : msg_word;
  assign sum   = op_x + op_y + op_m;
  assign mixed = (phase[0] ? quad_in.b : quad_in.d) ^ sum;

  always_comb begin
    case (phase)
      2'd0:    rotated = {mixed[31:0], mixed[63:32]};
      2'd1:    rotated = {mixed[23:0], mixed[63:24]};
      2'd2:    rotated = {mixed[15:0], mixed[63:16]};
      default: rotated = {mixed[62:0], mixed[63]};
    endcase
  end

  always_comb begin
    quad_out = quad_in;
    if (phase[0]) begin
      quad_out.c = sum;
      quad_out.b = rotated;
    end else begin
      quad_out.a = sum;
      quad_out.d = rotated;
    end
  end

endmodule

@@ sv/blake2b_compression_top.sv @@
// Top level of the BLAKE2b compression block: load handling, sequencer, work vector.
// Load requests give no result and leave the block ready for the next request.
// A compress request runs the rounds, four steps per G mixing on the shared unit,
// then delivers eight result words, one per cycle while out_ready is high.
// A new request is taken only once the eighth word has been delivered.
// Reset (synchronous, rst_n low) clears the chaining words to zero and returns to idle.
module blake2b_compression_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  blake2b_pkg::blk_req_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output blake2b_pkg::blk_res_t out_data
);
  import blake2b_pkg::*;

  state_t      state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  g_r, g_nxt;
  logic [3:0]  round_r, round_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;

  logic [63:0] chain_r [8];
  logic [63:0] chain_nxt [8];
  logic [63:0] v_r [4][4];
  logic [63:0] v_nxt [4][4];
  logic [63:0] v_mix [4][4];

  logic        in_acc;
  logic        out_acc;
  logic        last_step;
  logic        msg_we;
  logic [3:0]  msg_raddr;
  logic [63:0] msg_rdata;
  logic [3:0]  slot;
  logic [1:0]  row_amt [4];
  g_quad_t     quad_in;
  g_quad_t     quad_out;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign last_step = (phase_r == 2'd3) && (g_r == 3'd7) && (round_r == 4'(Rounds - 1));
  assign msg_we    = in_acc && (action_t'(in_data.action) == ACT_LOAD_MSG);

  // The read address is taken from the next counter values so the word is ready in time.
  assign slot      = {g_nxt, phase_nxt[1]};
  assign msg_raddr = SIGMA_ROWS[round_nxt][{slot, 2'b00} +: 4];

  blake2b_ram #(
    .WIDTH(64),
    .DEPTH(MsgDepth)
  ) u_msg_ram (
    .clk  (clk),
    .we   (msg_we),
    .waddr(in_data.index),
    .wdata(in_data.word),
    .raddr(msg_raddr),
    .rdata(msg_rdata)
  );

  assign quad_in = '{a: v_r[0][0], b: v_r[1][0], c: v_r[2][0], d: v_r[3][0]};

  blake2b_g_unit u_g_unit (
    .phase   (phase_r),
    .quad_in (quad_in),
    .msg_word(msg_rdata),
    .quad_out(quad_out)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (action_t'(in_data.action) == ACT_COMPRESS)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc && (out_idx_r == 3'd7)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready  = 1'b1;
      ST_RUN:    in_ready  = 1'b0;
      ST_FINISH: in_ready  = 1'b0;
      ST_OUT:    out_valid = 1'b1;
      default:   in_ready  = 1'b0;
    endcase
  end

  assign out_data = '{hash_word: chain_r[out_idx_r], word_index: out_idx_r,
                      last: (out_idx_r == 3'd7)};

  // Step counters: phase within G, G within round, round, and the result word index.
  always_comb begin
    phase_nxt   = 2'd0;
    g_nxt       = 3'd0;
    round_nxt   = 4'd0;
    out_idx_nxt = out_idx_r;
    if (state_r == ST_RUN && !last_step) begin
      phase_nxt = 2'(phase_r + 2'd1);
      g_nxt     = g_r;
      round_nxt = round_r;
      if (phase_r == 2'd3) begin
        g_nxt = 3'(g_r + 3'd1);
        if (g_r == 3'd7) begin
          round_nxt = 4'(round_r + 4'd1);
        end
      end
    end
    if (out_acc) begin
      out_idx_nxt = 3'(out_idx_r + 3'd1);
    end
  end

  // Row rotations after each G keep the active column at position 0. The fourth column
  // step also diagonalises the rows, and the fourth diagonal step restores them.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (g_r == 3'd3) begin
        row_amt[k] = 2'(k + 1);
      end else if (g_r == 3'd7) begin
        row_amt[k] = 2'(1 - k);
      end else begin
        row_amt[k] = 2'd1;
      end
    end
  end

  // Work vector.
  always_comb begin
    v_mix = v_r;
    v_mix[0][0] = quad_out.a;
    v_mix[1][0] = quad_out.b;
    v_mix[2][0] = quad_out.c;
    v_mix[3][0] = quad_out.d;
    v_nxt = v_r;
    if (in_acc && (action_t'(in_data.action) == ACT_COMPRESS)) begin
      for (int k = 0; k < 4; k++) begin
        v_nxt[0][k] = chain_r[k];
        v_nxt[1][k] = chain_r[k + 4];
        v_nxt[2][k] = IV[k];
      end
      v_nxt[3][0] = IV[4] ^ in_data.counter_low;
      v_nxt[3][1] = IV[5] ^ in_data.counter_high;
      v_nxt[3][2] = IV[6] ^ {64{in_data.final_block}};
      v_nxt[3][3] = IV[7] ^ {64{in_data.last_node}};
    end else if (state_r == ST_RUN) begin
      if (phase_r == 2'd3) begin
        for (int k = 0; k < 4; k++) begin
          for (int c = 0; c < 4; c++) begin
            v_nxt[k][c] = v_mix[k][2'(c + row_amt[k])];
          end
        end
      end else begin
        v_nxt = v_mix;
      end
    end
  end

  // Chaining words.
  always_comb begin
    chain_nxt = chain_r;
    if (in_acc && (action_t'(in_data.action) == ACT_LOAD_CHAIN) && !in_data.index[3]) begin
      chain_nxt[in_data.index[2:0]] = in_data.word;
    end else if (state_r == ST_FINISH) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] ^ v_r[i / 4][i % 4] ^ v_r[i / 4 + 2][i % 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= 2'd0;
      g_r       <= 3'd0;
      round_r   <= 4'd0;
      out_idx_r <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= 64'd0;
      end
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      g_r       <= g_nxt;
      round_r   <= round_nxt;
      out_idx_r <= out_idx_nxt;
      chain_r   <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  a_busy_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("block takes a request while results are pending");

  a_compress_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (action_t'(in_data.action) == ACT_COMPRESS)) |=> (state_r == ST_RUN))
    else $error("compress request did not start the rounds");

  a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (phase_r == 2'd0 && g_r == 3'd0 && round_r == 4'd0))
    else $error("step counters not cleared outside the rounds");

  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_data.last) |=>
      (out_valid && out_data.word_index == 3'($past(out_data.word_index) + 3'd1)))
    else $error("result words out of order");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.last) |=> in_ready)
    else $error("block not idle after the eighth result");

endmodule
